@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// BPD_ASSERT checks a property while reset is released.
// BPD_ASSERT_ALWAYS checks a property at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/bpd_pkg.sv @@
package bpd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 20;
    localparam int DEFAULT_COLOURS     = 19;
    localparam int RUN_LEN             = 16;
    localparam int CNT_W               = $clog2(RUN_LEN);
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(RUN_LEN - 1);

    // action codes
    localparam logic [1:0] ACT_PAL_WRITE = 2'd0;
    localparam logic [1:0] ACT_DECODE    = 2'd1;
    localparam logic [1:0] ACT_BORDER    = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    // video modes
    localparam logic [2:0] MODE_320X16     = 3'd0;
    localparam logic [2:0] MODE_320X4      = 3'd1;
    localparam logic [2:0] MODE_320X4_SPEC = 3'd2;
    localparam logic [2:0] MODE_160X16     = 3'd3;
    localparam logic [2:0] MODE_640X2      = 3'd4;
    localparam logic [2:0] MODE_MO_320X16  = 3'd5;

    // configuration register indexes
    localparam logic CFG_VIDEO_MODE   = 1'b0;
    localparam logic CFG_BORDER_COLOR = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] plane_high;
        logic [7:0] plane_low;
        logic [4:0] palette_index;
        logic [3:0] red;
        logic [3:0] green;
        logic [3:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic        last_pixel;
    } t_out_item;

    typedef struct packed {
        logic       en;
        logic [4:0] idx;
        logic [3:0] red;
        logic [3:0] green;
        logic [3:0] blue;
    } t_pal_wr;

    function automatic logic [7:0] gamma(input logic [3:0] step);
        logic [7:0] v;
        case (step)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd100;
            4'd2:    v = 8'd127;
            4'd3:    v = 8'd147;
            4'd4:    v = 8'd163;
            4'd5:    v = 8'd179;
            4'd6:    v = 8'd191;
            4'd7:    v = 8'd203;
            4'd8:    v = 8'd215;
            4'd9:    v = 8'd223;
            4'd10:   v = 8'd231;
            4'd11:   v = 8'd239;
            4'd12:   v = 8'd243;
            4'd13:   v = 8'd247;
            4'd14:   v = 8'd251;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // RGB565: top five bits of red, top six of green, top five of blue
    function automatic logic [15:0] make_colour(input logic [3:0] r,
                                                input logic [3:0] g,
                                                input logic [3:0] b);
        logic [7:0] rv;
        logic [7:0] gv;
        logic [7:0] bv;
        rv = gamma(r);
        gv = gamma(g);
        bv = gamma(b);
        return {rv[7:3], gv[7:2], bv[7:3]};
    endfunction

    // default steps as {red, green, blue}
    function automatic logic [11:0] default_rgb(input int idx);
        logic [11:0] v;
        case (idx)
            0:       v = 12'h000;
            1:       v = 12'hF00;
            2:       v = 12'h0F0;
            3:       v = 12'hFF0;
            4:       v = 12'h00F;
            5:       v = 12'hF0F;
            6:       v = 12'h0FF;
            7:       v = 12'hFFF;
            8:       v = 12'h777;
            9:       v = 12'hA33;
            10:      v = 12'h3A3;
            11:      v = 12'hAA3;
            12:      v = 12'h33A;
            13:      v = 12'hA3A;
            14:      v = 12'h7EE;
            15:      v = 12'hB30;
            16:      v = 12'hBBB;
            17:      v = 12'hEEE;
            18:      v = 12'h222;
            default: v = 12'h000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] default_colour(input int idx);
        logic [11:0] rgb;
        rgb = default_rgb(idx);
        if (idx < DEFAULT_COLOURS) begin
            return make_colour(rgb[11:8], rgb[7:4], rgb[3:0]);
        end
        return 16'h0000;
    endfunction

endpackage

@@ sv/bpd_palette.sv @@
`include "assert_macros.svh"

module bpd_palette #(
    parameter int PALETTE_ENTRIES = bpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpd_pkg::t_pal_wr i_wr,
    input  logic [3:0]      i_rd_idx,
    output logic [15:0]     o_rd_colour
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    logic [15:0]      r_palette [PALETTE_ENTRIES];
    logic             wr_ok;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      wr_colour;

    // drop writes past the last entry
    assign wr_ok     = i_wr.en && (32'(i_wr.idx) < PALETTE_ENTRIES);
    assign wr_idx    = i_wr.idx[IDX_W-1:0];
    assign wr_colour = bpd_pkg::make_colour(i_wr.red, i_wr.green, i_wr.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_palette[i] <= bpd_pkg::default_colour(i);
            end
        end else if (wr_ok) begin
            r_palette[wr_idx] <= wr_colour;
        end
    end

    assign o_rd_colour = r_palette[IDX_W'(i_rd_idx)];

    `BPD_ASSERT(a_pal_write_lands, i_clk, i_rst_n,
        wr_ok |=> (r_palette[$past(wr_idx)] == $past(wr_colour)), "palette write lost")

endmodule

@@ sv/bpd_dot_decode.sv @@
module bpd_dot_decode (
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_planes,
    input  logic [3:0]  i_pixel,
    output logic [3:0]  o_index
);

    logic [7:0] hi;
    logic [7:0] lo;
    logic [2:0] dot;

    assign hi  = i_planes[15:8];
    assign lo  = i_planes[7:0];
    // double-width dots: plane bit 7 first
    assign dot = ~i_pixel[3:1];

    always_comb begin
        unique case (i_mode)
            bpd_pkg::MODE_320X4: begin
                o_index = {2'b00, hi[dot], lo[dot]};
            end
            bpd_pkg::MODE_320X4_SPEC: begin
                o_index = {2'b00, i_planes[{dot, 1'b0} +: 2]};
            end
            bpd_pkg::MODE_160X16: begin
                o_index = i_planes[{~i_pixel[3:2], 2'b00} +: 4];
            end
            bpd_pkg::MODE_640X2: begin
                o_index = {3'b000, i_planes[~i_pixel]};
            end
            bpd_pkg::MODE_MO_320X16: begin
                o_index = hi[dot] ? lo[7:4] : lo[3:0];
            end
            default: begin
                // colour-form, also taken for unused mode codes
                o_index = hi[dot] ? {~lo[6], lo[5:3]} : {~lo[7], lo[2:0]};
            end
        endcase
    end

endmodule

@@ sv/bitplane_palette_pixel_decoder.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_data  (bpd_pkg::t_in_item)
// out      output     o_out_valid / i_out_stall o_out_data (bpd_pkg::t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Decode and border items each give a run of 16 pixels, one pixel per cycle
// out of the output register while the output does not stall; the pixel
// counter of the run stage walks the run. Palette writes and unused actions
// pass through the input register and start no run.
// The next item waits in the input register and enters the run stage in
// the cycle the last pixel of the current run moves to the output register.
// Reset (synchronous, active low) reloads the default palette.
// A stall on the output holds the run; the input stalls only while full.
`include "assert_macros.svh"

module bitplane_palette_pixel_decoder #(
    parameter int PALETTE_ENTRIES = bpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bpd_pkg::t_in_item  i_in_data,
    // pixel output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bpd_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    localparam int CNT_W = bpd_pkg::CNT_W;

    // configuration registers
    logic [2:0]        r_video_mode;
    logic [3:0]        r_border_color;

    // input register
    logic              r_in_valid;
    bpd_pkg::t_in_item r_in;

    // run stage
    logic              r_run_active;
    logic              r_run_border;
    logic [15:0]       r_held_planes;
    logic [CNT_W-1:0]  r_cnt;

    // output register
    logic              r_out_valid;
    logic [15:0]       r_out_pixel;
    logic              r_out_last;

    logic              n_run_active;
    logic              in_acc;
    logic              out_free;
    logic              run_adv;
    logic              run_done;
    logic              take;
    logic              starts_run;
    logic [3:0]        dot_idx;
    logic [3:0]        rd_idx;
    logic [15:0]       rd_colour;
    bpd_pkg::t_pal_wr  pal_wr;

    // Configuration: always ready; writes are to arrive only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode   <= 3'd0;
            r_border_color <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpd_pkg::CFG_VIDEO_MODE:   r_video_mode   <= i_cfg_data[2:0];
                bpd_pkg::CFG_BORDER_COLOR: r_border_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake control. The output register frees when empty or taken;
    // the run advances one pixel into it then. The waiting item is taken
    // when the run is idle or finishes this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign run_adv    = r_run_active && out_free;
    assign run_done   = run_adv && (r_cnt == bpd_pkg::RUN_LAST);
    assign take       = r_in_valid && (!r_run_active || run_done);
    assign starts_run = take && ((r_in.action == bpd_pkg::ACT_DECODE) ||
                                 (r_in.action == bpd_pkg::ACT_BORDER));
    assign o_in_stall = r_in_valid && !take;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Hold one transaction ahead of the run stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Palette write goes out at take time, so it lands after the last
    // pixel of the run ahead of it has read the palette.
    assign pal_wr.en    = take && (r_in.action == bpd_pkg::ACT_PAL_WRITE);
    assign pal_wr.idx   = r_in.palette_index;
    assign pal_wr.red   = r_in.red;
    assign pal_wr.green = r_in.green;
    assign pal_wr.blue  = r_in.blue;

    // Run stage: counter walks the 16 pixels of a decode or border run.
    always_comb begin
        if (starts_run) begin
            n_run_active = 1'b1;
        end else if (run_done) begin
            n_run_active = 1'b0;
        end else begin
            n_run_active = r_run_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active  <= 1'b0;
            r_cnt         <= '0;
            r_held_planes <= 16'h0000;
        end else begin
            r_run_active <= n_run_active;
            if (starts_run) begin
                r_cnt <= '0;
            end else if (run_adv) begin
                // wraps to zero after the last pixel
                r_cnt <= r_cnt + 1'b1;
            end
            if (take && (r_in.action == bpd_pkg::ACT_DECODE)) begin
                r_held_planes <= {r_in.plane_high, r_in.plane_low};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (starts_run) begin
            r_run_border <= (r_in.action == bpd_pkg::ACT_BORDER);
        end
    end

    bpd_dot_decode u_dot_decode (
        .i_mode   (r_video_mode),
        .i_planes (r_held_planes),
        .i_pixel  (r_cnt),
        .o_index  (dot_idx)
    );

    assign rd_idx = r_run_border ? r_border_color : dot_idx;

    bpd_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (pal_wr),
        .i_rd_idx    (rd_idx),
        .o_rd_colour (rd_colour)
    );

    // Output register: load a pixel on each run advance, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (run_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_adv) begin
            r_out_pixel <= rd_colour;
            r_out_last  <= (r_cnt == bpd_pkg::RUN_LAST);
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.pixel_rgb565 = r_out_pixel;
    assign o_out_data.last_pixel   = r_out_last;

    `BPD_ASSERT(a_idle_cnt_zero, i_clk, i_rst_n,
        !r_run_active |-> (r_cnt == '0), "pixel counter left a run unfinished")
    `BPD_ASSERT(a_last_flag, i_clk, i_rst_n,
        run_done |=> (r_out_valid && r_out_last), "sixteenth pixel not flagged")
    `BPD_ASSERT(a_mid_run, i_clk, i_rst_n,
        (run_adv && !run_done) |=> (r_run_active && !r_out_last),
        "run ended early")
    `BPD_ASSERT(a_no_take_mid_run, i_clk, i_rst_n,
        (r_run_active && !run_done) |=> $stable(r_run_border),
        "run source changed mid-run")

endmodule

@@ tb/tb_bitplane_palette_pixel_decoder.sv @@
module tb_bitplane_palette_pixel_decoder;

    localparam int          ENTRIES      = bpd_pkg::PALETTE_ENTRIES_DEF;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_TICKS = 24;
    localparam int          ITEMS_PER_PHASE = 21;
    localparam int          PHASES       = 10;
    localparam int          MAX_REPORTS  = 40;
    // spare mode codes, decoded like 320x16 colour-form
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;

    // gamma steps, step 0 in the low byte
    localparam logic [127:0] GAMMA_LUT = {
        8'd255, 8'd251, 8'd247, 8'd243, 8'd239, 8'd231, 8'd223, 8'd215,
        8'd203, 8'd191, 8'd179, 8'd163, 8'd147, 8'd127, 8'd100, 8'd0
    };
    // power-up colours as {red, green, blue} steps, entry 0 in the low bits
    localparam logic [19*12-1:0] POWERUP_STEPS = {
        12'h222, 12'hEEE, 12'hBBB, 12'hB30, 12'h7EE, 12'hA3A, 12'h33A,
        12'hAA3, 12'h3A3, 12'hA33, 12'h777, 12'hFFF, 12'h0FF, 12'hF0F,
        12'h00F, 12'hFF0, 12'h0F0, 12'hF00, 12'h000
    };

    typedef struct {
        bit          on;
        logic [15:0] colour;
    } t_fixed_colour;

    // one directed transaction plus the register values it runs under
    typedef struct {
        logic [3:0]        mode_cfg;
        logic [3:0]        border_cfg;
        bpd_pkg::t_in_item item;
        bit                typed;
        logic [15:0]       colour;
    } t_step_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    bpd_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    bpd_pkg::t_out_item o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = bpd_pkg::CFG_VIDEO_MODE;
    logic [3:0]         i_cfg_data = '0;

    // predictor state: palette copy and register copies
    logic [15:0]   palette_shadow [ENTRIES];
    logic [2:0]    mode_shadow;
    logic [3:0]    border_shadow;

    bpd_pkg::t_out_item pending_pixels [$];
    t_fixed_colour      fixed_q [$];
    t_step_row          directed_q [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  steady_run = 1'b0;
    int  cur_mode_cfg = -1;
    int  cur_border_cfg = -1;
    bpd_pkg::t_out_item want_px;
    t_fixed_colour      fixed_now;

    bitplane_palette_pixel_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build one RGB565 colour from three gamma steps.
    function automatic logic [15:0] shade(input logic [3:0] r, input logic [3:0] g,
                                          input logic [3:0] b);
        logic [15:0] rv;
        logic [15:0] gv;
        logic [15:0] bv;
        rv = 16'(GAMMA_LUT[r*8 +: 8]);
        gv = 16'(GAMMA_LUT[g*8 +: 8]);
        bv = 16'(GAMMA_LUT[b*8 +: 8]);
        return ((rv << 8) & 16'hF800) | ((gv << 3) & 16'h07E0) | (bv >> 3);
    endfunction

    // Palette index of pixel p of a decoded byte pair, planes read MSB first.
    function automatic logic [3:0] pixel_index(input logic [2:0] mode, input logic [7:0] hi,
                                               input logic [7:0] lo, input int p);
        logic [15:0] both;
        int          dot;
        both = {hi, lo};
        dot  = 7 - p / 2;
        case (mode)
            bpd_pkg::MODE_320X4:      return {2'b00, hi[dot], lo[dot]};
            bpd_pkg::MODE_320X4_SPEC: return {2'b00, both[14 - 2 * (p / 2) +: 2]};
            bpd_pkg::MODE_160X16:     return both[12 - 4 * (p / 4) +: 4];
            bpd_pkg::MODE_640X2:      return {3'b000, both[15 - p]};
            bpd_pkg::MODE_MO_320X16:  return hi[dot] ? lo[7:4] : lo[3:0];
            // colour-form, also taken by the spare mode codes
            default: return hi[dot] ? {~lo[6], lo[5:3]} : {~lo[7], lo[2:0]};
        endcase
    endfunction

    task automatic reset_shadow();
        logic [11:0] steps;
        for (int i = 0; i < ENTRIES; i++) begin
            steps = (i < bpd_pkg::DEFAULT_COLOURS) ? POWERUP_STEPS[i*12 +: 12] : 12'h000;
            palette_shadow[i] = (i < bpd_pkg::DEFAULT_COLOURS) ?
                                shade(steps[11:8], steps[7:4], steps[3:0]) : 16'h0000;
        end
        mode_shadow   = bpd_pkg::MODE_320X16;
        border_shadow = '0;
    endtask

    // Apply one accepted transaction to the predictor; queue the sixteen pixels of a decode or border run.
    task automatic predict_pixels(input bpd_pkg::t_in_item it, input t_fixed_colour fc);
        bpd_pkg::t_out_item px;
        logic [15:0]        col;
        case (it.action)
            bpd_pkg::ACT_PAL_WRITE: begin
                if (it.palette_index < ENTRIES)
                    palette_shadow[it.palette_index] = shade(it.red, it.green, it.blue);
            end
            bpd_pkg::ACT_DECODE, bpd_pkg::ACT_BORDER: begin
                for (int p = 0; p < bpd_pkg::RUN_LEN; p++) begin
                    if (fc.on)
                        col = fc.colour;
                    else if (it.action == bpd_pkg::ACT_DECODE)
                        col = palette_shadow[pixel_index(mode_shadow, it.plane_high,
                                                         it.plane_low, p)];
                    else
                        col = palette_shadow[border_shadow];
                    px.pixel_rgb565 = col;
                    px.last_pixel   = (p == bpd_pkg::RUN_LEN - 1);
                    pending_pixels.push_back(px);
                end
            end
            default: ;  // unused action: drop
        endcase
    endtask

    // Random gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bpd_pkg::t_in_item mk_item(input logic [1:0] act, input logic [7:0] hi,
                                                  input logic [7:0] lo, input logic [4:0] idx,
                                                  input logic [3:0] r, input logic [3:0] g,
                                                  input logic [3:0] b);
        bpd_pkg::t_in_item it;
        it.action        = act;
        it.plane_high    = hi;
        it.plane_low     = lo;
        it.palette_index = idx;
        it.red           = r;
        it.green         = g;
        it.blue          = b;
        return it;
    endfunction

    function automatic bpd_pkg::t_in_item rand_item();
        bpd_pkg::t_in_item it;
        int                r;
        it = mk_item(bpd_pkg::ACT_NONE, 8'($urandom), 8'($urandom), 5'($urandom),
                     4'($urandom), 4'($urandom), 4'($urandom));
        r = $urandom_range(0, 99);
        if (r < 45)      it.action = bpd_pkg::ACT_DECODE;
        else if (r < 70) it.action = bpd_pkg::ACT_BORDER;
        else if (r < 95) it.action = bpd_pkg::ACT_PAL_WRITE;
        else             it.action = bpd_pkg::ACT_NONE;
        // keep most palette writes on live entries
        if (it.action == bpd_pkg::ACT_PAL_WRITE && $urandom_range(0, 4) != 0)
            it.palette_index = 5'($urandom_range(0, ENTRIES - 1));
        return it;
    endfunction

    // Present one transaction and hold it until accepted. Valid is only
    // lowered when a gap follows, so it never toggles within one step.
    task automatic send_item(input bpd_pkg::t_in_item it, input int gap, input bit typed,
                             input logic [15:0] colour);
        t_fixed_colour fc;
        fc.on     = typed;
        fc.colour = colour;
        fixed_q.push_back(fc);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait until every queued pixel has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == bpd_pkg::CFG_VIDEO_MODE) mode_shadow = val[2:0];
        else                                border_shadow = val;
        @(posedge i_clk);
    endtask

    // Reprogram the registers only with the pipe empty; a palette write may
    // still sit in the input register after the last pixel, so settle first.
    task automatic set_regs(input logic [3:0] mode_cfg, input logic [3:0] border_cfg);
        if (cur_mode_cfg == int'(mode_cfg) && cur_border_cfg == int'(border_cfg))
            return;
        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (cur_mode_cfg != int'(mode_cfg))
            write_reg(bpd_pkg::CFG_VIDEO_MODE, mode_cfg);
        if (cur_border_cfg != int'(border_cfg))
            write_reg(bpd_pkg::CFG_BORDER_COLOR, border_cfg);
        cur_mode_cfg   = int'(mode_cfg);
        cur_border_cfg = int'(border_cfg);
    endtask

    task automatic add_row(input logic [3:0] mode_cfg, input logic [3:0] border_cfg,
                           input bpd_pkg::t_in_item it, input bit typed,
                           input logic [15:0] colour);
        t_step_row row;
        row.mode_cfg   = mode_cfg;
        row.border_cfg = border_cfg;
        row.item       = it;
        row.typed      = typed;
        row.colour     = colour;
        directed_q.push_back(row);
    endtask

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Input side: predict at every accepted transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            fixed_now = fixed_q.pop_front();
            predict_pixels(i_in_data, fixed_now);
        end
    end

    // Output side: compare each accepted pixel with the oldest expectation,
    // then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel: expected none actual %h last %b",
                             $time, o_out_data.pixel_rgb565, o_out_data.last_pixel);
            end else begin
                want_px = pending_pixels.pop_front();
                if (o_out_data.pixel_rgb565 !== want_px.pixel_rgb565) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: pixel_rgb565 mismatch: expected %h actual %h",
                                 $time, want_px.pixel_rgb565, o_out_data.pixel_rgb565);
                end
                if (o_out_data.last_pixel !== want_px.last_pixel) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: last_pixel mismatch: expected %b actual %b",
                                 $time, want_px.last_pixel, o_out_data.last_pixel);
                end
            end
        end
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!steady_run && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        i_out_stall <= (stall_left > 0);
    end

    initial begin
        bpd_pkg::t_in_item it;
        t_step_row         row;
        int                sent;
        logic [3:0]        mode_cfg;
        logic [3:0]        border_cfg;

        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: power-up palette, colour-form extremes, every mode,
        // palette writes at the range edges, unused action and mode codes.
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_BORDER, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_DECODE, 8'h00, 8'h80, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_DECODE, 8'hFF, 8'h7F, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'hFFFF);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_DECODE, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_DECODE, 8'hAA, 8'h55, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X4}, 4'd15,
                mk_item(bpd_pkg::ACT_BORDER, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X4}, 4'd15,
                mk_item(bpd_pkg::ACT_PAL_WRITE, 8'h00, 8'h00, 5'd15, 4'd15, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X4}, 4'd15,
                mk_item(bpd_pkg::ACT_BORDER, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'hF800);
        add_row({1'b0, bpd_pkg::MODE_320X4}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'hF0, 8'h0F, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X4_SPEC}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'h1B, 8'hE4, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_160X16}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'h01, 8'h23, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_160X16}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'hFE, 8'hDC, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_640X2}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'hFF, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_640X2}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'h5A, 8'hC3, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_DECODE, 8'hA5, 8'h7C, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        // writes past the last entry must leave the palette alone
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_PAL_WRITE, 8'hFF, 8'hFF, 5'd31, 4'd15, 4'd15, 4'd15),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_PAL_WRITE, 8'h00, 8'h00, 5'd20, 4'd15, 4'd15, 4'd15),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_PAL_WRITE, 8'h00, 8'h00, 5'd19, 4'd15, 4'd15, 4'd15),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_NONE, 8'hFF, 8'hFF, 5'd31, 4'd15, 4'd15, 4'd15),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_MO_320X16}, 4'd15,
                mk_item(bpd_pkg::ACT_BORDER, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'hF800);
        // spare mode codes, the second one with the unused top data bit set
        add_row({1'b0, MODE_SPARE_6}, 4'd7,
                mk_item(bpd_pkg::ACT_DECODE, 8'hC3, 8'h96, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b1, MODE_SPARE_7}, 4'd7,
                mk_item(bpd_pkg::ACT_DECODE, 8'h3C, 8'h69, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_PAL_WRITE, 8'h00, 8'h00, 5'd0, 4'd15, 4'd15, 4'd15),
                1'b0, 16'h0000);
        add_row({1'b0, bpd_pkg::MODE_320X16}, 4'd0,
                mk_item(bpd_pkg::ACT_BORDER, 8'h00, 8'h00, 5'd0, 4'd0, 4'd0, 4'd0),
                1'b1, 16'hFFFF);

        foreach (directed_q[i]) begin
            row = directed_q[i];
            set_regs(row.mode_cfg, row.border_cfg);
            send_item(row.item, idle_len(), row.typed, row.colour);
        end

        // Random part: phases under different register settings, extremes
        // first; every fourth phase runs with no gaps on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                mode_cfg   = {1'b0, bpd_pkg::MODE_320X16};
                border_cfg = 4'd0;
            end else if (phase == 1) begin
                mode_cfg   = {1'b0, bpd_pkg::MODE_MO_320X16};
                border_cfg = 4'd15;
            end else begin
                mode_cfg   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                          4'($urandom_range(0, 5));
                border_cfg = 4'($urandom_range(0, 15));
            end
            set_regs(mode_cfg, border_cfg);
            steady_run = (phase % 4 == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                it = rand_item();
                send_item(it, steady_run ? 0 : idle_len(), 1'b0, 16'h0000);
                if (it.action == bpd_pkg::ACT_DECODE || it.action == bpd_pkg::ACT_BORDER ||
                    (it.action == bpd_pkg::ACT_PAL_WRITE && it.palette_index < ENTRIES))
                    sent++;
                // hold the sender midway through one phase until the pipe runs dry
                if (phase == 3 && sent == ITEMS_PER_PHASE / 2)
                    drain();
            end
        end
        steady_run = 1'b0;

        // Wind down: let every queued pixel out, then watch for strays.
        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
